[sv/tlpt_pkg.sv]
// -----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the two-level page table engine
// Request and queue types, mode and status codes, and address field layout.
// -----------------------------------------------------------------------------
package tlpt_pkg;

    // Default sizing of the table pool
    localparam int TABLE_SLOTS_DEF      = 16;
    localparam int PRELOADED_TABLES_DEF = 8;

    // Linear address layout
    localparam int DIR_IDX_W   = 10;
    localparam int DIR_ENTRIES = 1024;
    localparam int OFFSET_W    = 12;
    localparam int DIR_SHIFT   = 22;
    localparam int FRAME_W     = 32 - OFFSET_W;

    localparam logic [31:0] IDENT_FLAGS = 32'h0000_0007;

    // Request kinds
    localparam logic [1:0] MODE_MAP   = 2'd0;
    localparam logic [1:0] MODE_UNMAP = 2'd1;
    localparam logic [1:0] MODE_XLATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_DIR_ABSENT = 2'd1;
    localparam logic [1:0] ST_PTE_ABSENT = 2'd2;
    localparam logic [1:0] ST_NO_TABLE   = 2'd3;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [DIR_IDX_W-1:0] didx;
        logic [DIR_IDX_W-1:0] tidx;
        logic [OFFSET_W-1:0]  offset;
        logic [31:0]          pte;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_head;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_stat;

endpackage

[sv/tlpt_front.sv]
// -----------------------------------------------------------------------------
// tlpt_front: request intake
// Takes requests, splits the linear address and builds the page entry, and
// holds them in a short queue for the walker.
// -----------------------------------------------------------------------------
module tlpt_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [31:0]            i_virt_addr,
    input  logic [31:0]            i_phys_addr,
    input  logic [11:0]            i_page_flags,
    input  tlpt_pkg::t_back_stat   i_stat,
    output tlpt_pkg::t_head        o_head
);
    import tlpt_pkg::*;

    t_req               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               push;
    t_req               new_req;

    assign o_in_ready = (r_count != Q_CNT_W'(Q_DEPTH)) && !i_stat.init_busy;
    assign push       = i_in_valid && o_in_ready;

    always_comb begin
        new_req.mode   = i_mode;
        new_req.didx   = i_virt_addr[31:DIR_SHIFT];
        new_req.tidx   = i_virt_addr[DIR_SHIFT-1:OFFSET_W];
        new_req.offset = i_virt_addr[OFFSET_W-1:0];
        new_req.pte    = {i_phys_addr[31:OFFSET_W], i_page_flags};
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_stat.pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_stat.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_stat.pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= new_req;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_q[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("request queue holds more than its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.pop |-> (r_count != '0))
        else $error("walker took a request from an empty queue");

    a_no_push_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.init_busy |-> !push)
        else $error("request taken during table initialisation");

endmodule

[sv/tlpt_back.sv]
// -----------------------------------------------------------------------------
// tlpt_back: table walker
// Holds the page directory and the table pool, fills them after reset,
// carries out map, unmap and translate, and registers the result.
// -----------------------------------------------------------------------------
module tlpt_back #(
    parameter int TABLE_SLOTS      = tlpt_pkg::TABLE_SLOTS_DEF,
    parameter int PRELOADED_TABLES = tlpt_pkg::PRELOADED_TABLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlpt_pkg::t_head      i_head,
    output tlpt_pkg::t_back_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_out_phys_result,
    output logic [1:0]           o_out_status
);
    import tlpt_pkg::*;

    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int TAB_AW      = SLOT_W + DIR_IDX_W;
    localparam int TAB_DEPTH   = TABLE_SLOTS * DIR_ENTRIES;
    localparam int FREE_W      = $clog2(TABLE_SLOTS + 1);
    localparam int PRE_N       = (PRELOADED_TABLES > TABLE_SLOTS) ? TABLE_SLOTS
                                                                  : PRELOADED_TABLES;
    localparam int PRE_ENTRIES = PRE_N * DIR_ENTRIES;
    localparam int INIT_LAST   = ((PRE_N > 0) ? PRE_N : 1) * DIR_ENTRIES - 1;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIR   = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_TRD   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // Directory entry: present bit above the slot number
    logic [SLOT_W:0] r_dir_mem [DIR_ENTRIES];
    logic [31:0]     r_tab_mem [TAB_DEPTH];

    logic [2:0]        r_state, n_state;
    logic [TAB_AW-1:0] r_cnt, n_cnt;
    logic [FREE_W-1:0] r_free, n_free;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_req              r_req, n_req;
    logic [31:0]       r_res_phys, n_res_phys;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_phys;
    logic [1:0]        r_out_status;
    logic              out_load;
    logic [SLOT_W:0]   r_dir_q;
    logic [31:0]       r_tab_q;

    logic                 dir_we, dir_re;
    logic [DIR_IDX_W-1:0] dir_waddr, dir_raddr;
    logic [SLOT_W:0]      dir_wdata;
    logic                 tab_we, tab_re;
    logic [TAB_AW-1:0]    tab_waddr, tab_raddr;
    logic [31:0]          tab_wdata;

    logic              dir_present;
    logic [SLOT_W-1:0] dir_slot;
    logic              init_pre;

    assign dir_present = r_dir_q[SLOT_W];
    assign dir_slot    = r_dir_q[SLOT_W-1:0];
    assign init_pre    = 32'(r_cnt) < PRE_N;
    assign tab_raddr   = {dir_slot, r_req.tidx};
    assign dir_raddr   = i_head.req.didx;

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_free           = r_free;
        n_slot           = r_slot;
        n_req            = r_req;
        n_res_phys       = r_res_phys;
        n_res_status     = r_res_status;
        out_load         = 1'b0;
        o_stat.pop       = 1'b0;
        o_stat.init_busy = (r_state == S_INIT);
        dir_we           = 1'b0;
        dir_re           = 1'b0;
        dir_waddr        = r_req.didx;
        dir_wdata        = {1'b1, r_slot};
        tab_we           = 1'b0;
        tab_re           = 1'b0;
        tab_waddr        = {r_slot, r_req.tidx};
        tab_wdata        = r_req.pte;

        unique case (r_state)
            S_INIT: begin
                // Directory and identity tables are written in one sweep
                dir_we    = 32'(r_cnt) < DIR_ENTRIES;
                dir_waddr = r_cnt[DIR_IDX_W-1:0];
                dir_wdata = {init_pre, init_pre ? r_cnt[SLOT_W-1:0] : {SLOT_W{1'b0}}};
                tab_we    = 32'(r_cnt) < PRE_ENTRIES;
                tab_waddr = r_cnt;
                tab_wdata = (32'(r_cnt >> DIR_IDX_W) << DIR_SHIFT)
                          | (32'(r_cnt[DIR_IDX_W-1:0]) << OFFSET_W)
                          | IDENT_FLAGS;
                n_cnt     = r_cnt + 1'b1;
                if (32'(r_cnt) == INIT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_stat.pop = 1'b1;
                    dir_re     = 1'b1;
                    n_req      = i_head.req;
                    n_state    = S_DIR;
                end
            end
            S_DIR: begin
                n_res_phys   = '0;
                n_res_status = ST_DONE;
                n_state      = S_RESP;
                tab_waddr    = {dir_slot, r_req.tidx};
                unique case (r_req.mode)
                    MODE_MAP: begin
                        if (dir_present) begin
                            tab_we = 1'b1;
                        end else if (r_free >= FREE_W'(TABLE_SLOTS)) begin
                            n_res_status = ST_NO_TABLE;
                        end else begin
                            n_slot  = r_free[SLOT_W-1:0];
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                    end
                    MODE_UNMAP: begin
                        if (dir_present) begin
                            tab_we    = 1'b1;
                            tab_wdata = '0;
                        end else begin
                            n_res_status = ST_DIR_ABSENT;
                        end
                    end
                    MODE_XLATE: begin
                        if (dir_present) begin
                            tab_re  = 1'b1;
                            n_state = S_TRD;
                        end else begin
                            n_res_status = ST_DIR_ABSENT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CLEAR: begin
                tab_we    = 1'b1;
                tab_waddr = {r_slot, r_cnt[DIR_IDX_W-1:0]};
                tab_wdata = '0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt[DIR_IDX_W-1:0] == {DIR_IDX_W{1'b1}}) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                tab_we  = 1'b1;
                dir_we  = 1'b1;
                n_free  = r_free + 1'b1;
                n_state = S_RESP;
            end
            S_TRD: begin
                if (r_tab_q[0]) begin
                    n_res_phys   = {r_tab_q[31:OFFSET_W], r_req.offset};
                    n_res_status = ST_DONE;
                end else begin
                    n_res_phys   = '0;
                    n_res_status = ST_PTE_ABSENT;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_free      <= FREE_W'(PRE_N);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_req        <= n_req;
        r_res_phys   <= n_res_phys;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_phys   <= r_res_phys;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_q <= r_dir_mem[dir_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re) begin
            r_tab_q <= r_tab_mem[tab_raddr];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_phys_result = r_out_phys;
    assign o_out_status      = r_out_status;

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.init_busy |-> !o_stat.pop)
        else $error("request taken before the tables were initialised");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FREE_W'(TABLE_SLOTS))
        else $error("free table counter beyond the pool");

    a_clear_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_free < FREE_W'(TABLE_SLOTS)))
        else $error("clearing a table while the pool is exhausted");

    a_link_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (r_free == $past(r_free) + 1'b1))
        else $error("linking a table did not advance the free counter");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_DONE)) |-> (r_out_phys == '0))
        else $error("failed request returned a non-zero address");

endmodule

[sv/two_level_page_table_engine_core.sv]
// -----------------------------------------------------------------------------
// two_level_page_table_engine_core: two-level page table engine
// Page directory and page table pool that map, unmap and translate 32-bit
// linear addresses.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      i_in_valid / o_in_ready      i_mode, i_virt_addr,
//                                                    i_phys_addr, i_page_flags
//   out      output     o_out_valid / i_out_ready    o_out_phys_result,
//                                                    o_out_status
//
// A translate passes the walker as directory read, table read, result and
// hand-off; map and unmap write the entry instead of reading it. Each
// memory has one read and one write port. A map that links a new table
// first clears a free table, then writes the entry and links the table.
// After reset the walker fills the directory and the preloaded identity
// tables with o_in_ready low. A two-entry request queue and a result
// register let intake and walker stall independently.
// -----------------------------------------------------------------------------
module two_level_page_table_engine_core #(
    parameter int TABLE_SLOTS      = tlpt_pkg::TABLE_SLOTS_DEF,
    parameter int PRELOADED_TABLES = tlpt_pkg::PRELOADED_TABLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_phys_result,
    output logic [1:0]  o_out_status
);
    import tlpt_pkg::*;

    t_head      head;
    t_back_stat back_stat;

    tlpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_virt_addr  (i_virt_addr),
        .i_phys_addr  (i_phys_addr),
        .i_page_flags (i_page_flags),
        .i_stat       (back_stat),
        .o_head       (head)
    );

    tlpt_back #(
        .TABLE_SLOTS      (TABLE_SLOTS),
        .PRELOADED_TABLES (PRELOADED_TABLES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_stat            (back_stat),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_phys_result (o_out_phys_result),
        .o_out_status      (o_out_status)
    );

endmodule
